// File: design/svm_pkg.sv
// Shared types, codes and defaults for the sample voice mixer.
package svm_pkg;

  localparam int VOICES_DEF     = 4;
  localparam int NUM_WAVES_DEF  = 4;
  localparam int WAVE_DEPTH_DEF = 4096;

  typedef enum logic [2:0] {
    REQ_WRITE   = 3'd0,
    REQ_SET_LEN = 3'd1,
    REQ_PLAY    = 3'd2,
    REQ_LOOP    = 3'd3,
    REQ_STOP    = 3'd4,
    REQ_TICK    = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_IDLE    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_EXEC,
    SEQ_MIX,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctrl_t;

endpackage

// File: design/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/svm_div.sv
// Signed divide by the voice count, truncating toward zero, by reciprocal multiply.
module svm_div import svm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dividend_i,
  output logic               done_o,
  output logic signed [31:0] quotient_o
);

  // Ceiling reciprocal scaled by 2^(32 + clog2(VOICES)): the floor is exact
  // for every 32-bit magnitude.
  localparam int SH_L  = $clog2(VOICES);
  localparam int SHIFT = 32 + SH_L;
  localparam longint unsigned RECIP_I =
    ((64'd1 << SHIFT) + 64'(VOICES) - 64'd1) / 64'(VOICES);
  localparam logic [33:0] RECIP = 34'(RECIP_I);

  logic        run_q, done_q, neg_q;
  logic [31:0] mag_q, quot_q;
  logic [31:0] mag;
  logic [71:0] prod;

  assign mag  = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
  assign prod = 72'(mag_q) * 72'(RECIP);

  // capture the operand, then register the multiply result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= start_i;
      done_q <= run_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag;
      neg_q <= dividend_i[31];
    end
    if (run_q) begin
      quot_q <= prod[SHIFT +: 32];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quot_q + 32'd1) : quot_q;

endmodule

// File: design/svm_acc.sv
// Wide mix accumulator with saturation to 32 signed bits.
module svm_acc import svm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic               clk_i,
  input  acc_ctrl_t          ctrl_i,
  input  logic signed [31:0] addend_i,
  output logic signed [31:0] sum_o
);

  // Holds the exact sum of two samples per voice.
  localparam int ACC_W = 33 + $clog2(VOICES);
  localparam logic signed [ACC_W-1:0] MAX_V = $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff});
  localparam logic signed [ACC_W-1:0] MIN_V = $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});

  logic signed [ACC_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      sum_q <= '0;
    end else if (ctrl_i.add) begin
      sum_q <= sum_q + ACC_W'(addend_i);
    end
  end

  always_comb begin
    if (sum_q > MAX_V) begin
      sum_o = 32'sh7fff_ffff;
    end else if (sum_q < MIN_V) begin
      sum_o = $signed(32'h8000_0000);
    end else begin
      sum_o = sum_q[31:0];
    end
  end

endmodule

// File: design/sample_voice_mixer_core.sv
// Top level of the wavetable sample playback mixer.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------------
//  request | in  | in_valid_i / in_ready_o | req_type, wave_id, sample_addr,
//          |     |                        | sample_value, wave_len, slot_index
//  result  | out | out_valid_o/out_ready_i | status, slot_out, mix_sample, active_voices
//
// One item at a time. A sample write passes through the divider (operand
// capture, then the reciprocal multiply). A tick makes one sample-memory read
// per slot through the single read port. Reset clears slot busy flags and
// wave-length valid bits; sample memory has no reset. The result sits in an
// output register; a stalled result holds the sequencer in its last state
// until it is taken.
module sample_voice_mixer_core import svm_pkg::*; #(
  parameter int VOICES     = VOICES_DEF,
  parameter int NUM_WAVES  = NUM_WAVES_DEF,
  parameter int WAVE_DEPTH = WAVE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic [1:0]         wave_id_i,
  input  logic [11:0]        sample_addr_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [12:0]        wave_len_i,
  input  logic [1:0]         slot_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [1:0]         slot_out_o,
  output logic signed [31:0] mix_sample_o,
  output logic [3:0]         active_voices_o
);

  // Slots 0..VOICES-1 are one-shot, VOICES..2*VOICES-1 loop.
  localparam int NSLOT    = 2 * VOICES;
  localparam int IDX_W    = $clog2(NSLOT);
  localparam int CNT_W    = $clog2(NSLOT + 1);
  localparam int SW       = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int WID_W    = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
  localparam int POS_W    = $clog2(WAVE_DEPTH);
  localparam int LEN_W    = $clog2(WAVE_DEPTH + 1);
  localparam int STORE_D  = NUM_WAVES * WAVE_DEPTH;
  localparam int SA_W     = $clog2(STORE_D);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(WAVE_DEPTH);
  localparam logic [CNT_W-1:0] NSLOT_C   = CNT_W'(NSLOT);

  seq_state_e state_q, state_d;

  // captured request
  logic [2:0]  req_type_q;
  logic [1:0]  wave_id_q, slot_index_q;
  logic [11:0] addr_q;
  logic [12:0] wave_len_q;

  // result in progress
  status_e     res_status_q, res_status_d;
  logic [1:0]  res_slot_q, res_slot_d;

  // output register
  logic        out_valid_q;
  status_e     out_status_q;
  logic [1:0]  out_slot_q;
  logic signed [31:0] out_mix_q;
  logic [3:0]  out_active_q;

  // voice slots
  logic [NSLOT-1:0] busy_q;
  logic [WID_W-1:0] wave_q [NSLOT];
  logic [POS_W-1:0] pos_q  [NSLOT];

  // wave lengths
  logic [NUM_WAVES-1:0] len_vld_q;
  logic                 len_rd_vld_q;
  logic [WID_W-1:0]     len_raddr;
  logic [LEN_W-1:0]     len_rdata, cur_len, set_len;
  logic                 len_we;

  // tick scan
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] issue_idx, proc_idx_q;
  logic             proc_vld_q;

  logic               accept, wave_ok, addr_ok, is_tick;
  logic               div_done;
  logic signed [31:0] quotient, sample_rdata, mix_sat;
  logic [SA_W-1:0]    store_waddr, store_raddr;
  logic               store_we;
  acc_ctrl_t          acc_ctrl;

  // slot update controls
  logic             take_en, stop_en, adv_en, adv_wrap;
  logic [IDX_W-1:0] take_idx, stop_idx;
  logic [LEN_W-1:0] next_pos;
  logic [VOICES-1:0] free_vec;
  logic             free_found;
  logic [SW-1:0]    free_idx;
  logic [CNT_W-1:0] busy_cnt;
  logic [3:0]       active_cnt;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SEQ_IDLE);
  assign wave_ok    = int'(wave_id_q) < NUM_WAVES;
  assign addr_ok    = int'(addr_q) < WAVE_DEPTH;
  assign is_tick    = (req_type_q == REQ_TICK);
  assign issue_idx  = cnt_q[IDX_W-1:0];

  // ---------------------------------------------------------------- units
  svm_div #(.VOICES(VOICES)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && (req_type_i == REQ_WRITE)),
    .dividend_i (sample_value_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign acc_ctrl.clr = accept;
  assign acc_ctrl.add = proc_vld_q && busy_q[proc_idx_q];

  svm_acc #(.VOICES(VOICES)) u_acc (
    .clk_i    (clk_i),
    .ctrl_i   (acc_ctrl),
    .addend_i (sample_rdata),
    .sum_o    (mix_sat)
  );

  // Sample memory: wave * WAVE_DEPTH + position.
  assign store_we    = (state_q == SEQ_DIV) && div_done && wave_ok && addr_ok;
  assign store_waddr = SA_W'(SA_W'(WID_W'(wave_id_q)) * SA_W'(WAVE_DEPTH))
                     + SA_W'(POS_W'(addr_q));
  assign store_raddr = SA_W'(SA_W'(wave_q[issue_idx]) * SA_W'(WAVE_DEPTH))
                     + SA_W'(pos_q[issue_idx]);

  svm_ram #(.WIDTH(32), .DEPTH(STORE_D), .AW(SA_W)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (quotient),
    .raddr_i (store_raddr),
    .rdata_o (sample_rdata)
  );

  // Length table: read at accept for play/loop, per slot during a tick.
  assign len_raddr = (state_q == SEQ_MIX) ? wave_q[issue_idx] : WID_W'(wave_id_i);
  assign set_len   = ({19'd0, wave_len_q} > 32'(WAVE_DEPTH)) ? DEPTH_LEN
                                                             : LEN_W'(wave_len_q);
  assign len_we    = (state_q == SEQ_EXEC) && (req_type_q == REQ_SET_LEN) && wave_ok;

  svm_ram #(.WIDTH(LEN_W), .DEPTH(NUM_WAVES), .AW(WID_W)) u_len (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (WID_W'(wave_id_q)),
    .wdata_i (set_len),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // A wave never given a length reads as empty.
  assign cur_len = len_rd_vld_q ? len_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q    <= '0;
      len_rd_vld_q <= 1'b0;
    end else begin
      len_rd_vld_q <= (int'(len_raddr) < NUM_WAVES) && len_vld_q[len_raddr];
      if (len_we) begin
        len_vld_q[WID_W'(wave_id_q)] <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------- slot decisions
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      free_vec[i] = (req_type_q == REQ_LOOP) ? !busy_q[VOICES + i] : !busy_q[i];
    end
  end

  // lowest free slot of the addressed kind
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!free_found && free_vec[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign take_idx = (req_type_q == REQ_LOOP) ? IDX_W'(VOICES) + IDX_W'(free_idx)
                                             : IDX_W'(free_idx);
  assign stop_idx = IDX_W'(VOICES + int'(slot_index_q));

  always_comb begin
    take_en      = 1'b0;
    stop_en      = 1'b0;
    res_status_d = ST_OK;
    res_slot_d   = 2'd0;
    if (state_q == SEQ_EXEC) begin
      unique case (req_type_q)
        REQ_PLAY, REQ_LOOP: begin
          if (!wave_ok || (cur_len == '0)) begin
            res_status_d = ST_EMPTY;
          end else if (!free_found) begin
            res_status_d = ST_NO_SLOT;
          end else begin
            take_en    = 1'b1;
            res_slot_d = 2'(free_idx);
          end
        end
        REQ_STOP: begin
          if ((int'(slot_index_q) >= VOICES) || !busy_q[stop_idx]) begin
            res_status_d = ST_IDLE;
          end else begin
            stop_en = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Tick advance of the slot whose sample arrives this cycle.
  assign adv_en   = proc_vld_q && busy_q[proc_idx_q];
  assign next_pos = LEN_W'(pos_q[proc_idx_q]) + LEN_W'(1);
  assign adv_wrap = (next_pos >= cur_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      if (take_en) begin
        busy_q[take_idx] <= 1'b1;
      end
      if (stop_en) begin
        busy_q[stop_idx] <= 1'b0;
      end
      // one-shot voices end at the wave end, loops stay busy
      if (adv_en && adv_wrap && (int'(proc_idx_q) < VOICES)) begin
        busy_q[proc_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_en) begin
      wave_q[take_idx] <= WID_W'(wave_id_q);
      pos_q[take_idx]  <= '0;
    end
    if (adv_en) begin
      pos_q[proc_idx_q] <= adv_wrap ? '0 : POS_W'(next_pos);
    end
  end

  // busy slots after the item, saturated at 15
  always_comb begin
    busy_cnt = '0;
    for (int i = 0; i < NSLOT; i++) begin
      busy_cnt = busy_cnt + CNT_W'(busy_q[i]);
    end
    active_cnt = (int'(busy_cnt) > 15) ? 4'd15 : 4'(busy_cnt);
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_WRITE) begin
            state_d = SEQ_DIV;
          end else if (req_type_i == REQ_TICK) begin
            state_d = SEQ_MIX;
          end else begin
            state_d = SEQ_EXEC;
          end
        end
      end
      SEQ_DIV: begin
        if (div_done) begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_EXEC: state_d = SEQ_DONE;
      SEQ_MIX: begin
        if (cnt_q == NSLOT_C) begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      proc_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      proc_vld_q <= (state_q == SEQ_MIX) && (cnt_q < NSLOT_C);
      if (accept) begin
        cnt_q <= '0;
      end else if ((state_q == SEQ_MIX) && (cnt_q < NSLOT_C)) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if ((state_q == SEQ_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= issue_idx;
    if (accept) begin
      req_type_q   <= req_type_i;
      wave_id_q    <= wave_id_i;
      addr_q       <= sample_addr_i;
      wave_len_q   <= wave_len_i;
      slot_index_q <= slot_index_i;
      res_status_q <= ST_OK;
      res_slot_q   <= 2'd0;
    end else if (state_q == SEQ_EXEC) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
    end
    if ((state_q == SEQ_DONE) && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_mix_q    <= is_tick ? mix_sat : 32'sd0;
      out_active_q <= active_cnt;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_out_o      = out_slot_q;
  assign mix_sample_o    = out_mix_q;
  assign active_voices_o = out_active_q;

endmodule

// File: verif/tb_sample_voice_mixer_core.sv
// Self-checking testbench for sample_voice_mixer_core: directed table plus random requests.
`timescale 1ns / 1ps

module tb_sample_voice_mixer_core;
  import svm_pkg::*;

  localparam int VOICES     = VOICES_DEF;
  localparam int NUM_WAVES  = NUM_WAVES_DEF;
  localparam int WAVE_DEPTH = WAVE_DEPTH_DEF;

  // Request codes the block has no name for; both must be ignored.
  localparam logic [2:0] REQ_UNUSED_A = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B = 3'd7;

  localparam longint MIX_MAX    = 64'sd2147483647;
  localparam longint MIX_MIN    = -64'sd2147483648;
  localparam int     RAND_ITEMS = 1125;
  localparam int     DIR_ITEMS  = 25;
  // Cycles without any handshake before the run is declared hung. The slowest item
  // is a tick plus random stalls on both sides, so this is far beyond it.
  localparam int     QUIET_LIMIT = 5000;
  // The longest request is a tick.
  localparam int     DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [2:0]         req;
    logic [1:0]         wave;
    logic [11:0]        addr;
    logic signed [31:0] value;
    logic [12:0]        len;
    logic [1:0]         slot;
  } mix_req_t;

  typedef struct packed {
    status_e            status;
    logic [1:0]         slot;
    logic signed [31:0] mix;
    logic [3:0]         active;
  } mix_rsp_t;

  typedef struct packed {
    mix_req_t rq;
    logic     typed;   // 1: rsp below is the expected result, else use the predictor
    mix_rsp_t rsp;
  } dir_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [2:0]         req_type_i     = '0;
  logic [1:0]         wave_id_i      = '0;
  logic [11:0]        sample_addr_i  = '0;
  logic signed [31:0] sample_value_i = '0;
  logic [12:0]        wave_len_i     = '0;
  logic [1:0]         slot_index_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [1:0]         status_o;
  logic [1:0]         slot_out_o;
  logic signed [31:0] mix_sample_o;
  logic [3:0]         active_voices_o;

  sample_voice_mixer_core dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: sample memory, wave lengths, one-shot and looping voices.
  // ---------------------------------------------------------------------------
  int pcm_mem   [NUM_WAVES*WAVE_DEPTH];
  int wave_size [NUM_WAVES];
  bit one_on    [VOICES];
  int one_src   [VOICES];
  int one_idx   [VOICES];
  bit rep_on    [VOICES];
  int rep_src   [VOICES];
  int rep_idx   [VOICES];

  // Stimulus bookkeeping: which samples hold data, and how long the written
  // run from address zero is. Lengths never exceed that run while a tick can
  // follow, so no voice ever reads a sample that was not written.
  bit filled    [NUM_WAVES][WAVE_DEPTH];
  int wr_prefix [NUM_WAVES];

  mix_rsp_t pending_results[$];
  int       errors;
  bit       no_gaps;
  int       n_items, n_ticks, n_clipped, n_refused, n_writes;

  // One result per request; state updates follow the block's rules exactly.
  function automatic mix_rsp_t mix_result_of(mix_req_t rq);
    mix_rsp_t r;
    longint   acc;
    int       pick;
    int       busy;
    r    = '{ST_OK, 2'd0, 32'sd0, 4'd0};
    acc  = 0;
    pick = -1;
    busy = 0;
    case (rq.req)
      REQ_WRITE: begin
        // Divided by the voice count, truncated toward zero.
        pcm_mem[{rq.wave, rq.addr}] = int'(longint'($signed(rq.value)) / VOICES);
      end
      REQ_SET_LEN: begin
        wave_size[rq.wave] = (rq.len > WAVE_DEPTH) ? WAVE_DEPTH : int'(rq.len);
      end
      REQ_PLAY, REQ_LOOP: begin
        if (wave_size[rq.wave] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // scan downward so the lowest free slot wins
          for (int i = VOICES - 1; i >= 0; i--) begin
            if (rq.req == REQ_PLAY ? !one_on[i] : !rep_on[i]) pick = i;
          end
          if (pick < 0) begin
            r.status = ST_NO_SLOT;
          end else if (rq.req == REQ_PLAY) begin
            r.slot        = pick[1:0];
            one_on[pick]  = 1'b1;
            one_src[pick] = int'(rq.wave);
            one_idx[pick] = 0;
          end else begin
            r.slot        = pick[1:0];
            rep_on[pick]  = 1'b1;
            rep_src[pick] = int'(rq.wave);
            rep_idx[pick] = 0;
          end
        end
      end
      REQ_STOP: begin
        if (!rep_on[rq.slot]) begin
          r.status = ST_IDLE;
        end else begin
          rep_on[rq.slot]  = 1'b0;
          rep_src[rq.slot] = 0;
          rep_idx[rq.slot] = 0;
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < VOICES; i++) begin
          if (one_on[i]) begin
            acc += pcm_mem[one_src[i]*WAVE_DEPTH + one_idx[i]];
            one_idx[i]++;
            // end test is >=, so a shortened wave ends after the current sample
            if (one_idx[i] >= wave_size[one_src[i]]) begin
              one_on[i]  = 1'b0;
              one_src[i] = 0;
              one_idx[i] = 0;
            end
          end
          if (rep_on[i]) begin
            acc += pcm_mem[rep_src[i]*WAVE_DEPTH + rep_idx[i]];
            rep_idx[i]++;
            if (rep_idx[i] >= wave_size[rep_src[i]]) rep_idx[i] = 0;
          end
        end
        if (acc > MIX_MAX) r.mix = 32'sh7FFFFFFF;
        else if (acc < MIX_MIN) r.mix = 32'sh80000000;
        else r.mix = acc[31:0];
      end
      default: ;  // unknown requests change nothing
    endcase
    for (int i = 0; i < VOICES; i++) busy += int'(one_on[i]) + int'(rep_on[i]);
    r.active = (busy > 15) ? 4'd15 : busy[3:0];
    return r;
  endfunction

  // A length that is safe to play: within the written run, kept short so
  // that voices end and wrap often.
  function automatic logic [12:0] safe_len(int w);
    int top;
    top = (wr_prefix[w] > 48) ? 48 : wr_prefix[w];
    if (top == 0 || $urandom_range(99) < 12) return 13'd0;
    return 13'($urandom_range(top, 1));
  endfunction

  // Drive one item, wait for the handshake, then record what must come back.
  task automatic issue_item(input mix_req_t rq, input logic typed, input mix_rsp_t given);
    mix_rsp_t pred;
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rq.req;
    wave_id_i      <= rq.wave;
    sample_addr_i  <= rq.addr;
    sample_value_i <= rq.value;
    wave_len_i     <= rq.len;
    slot_index_i   <= rq.slot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = mix_result_of(rq);
    pending_results.push_back(typed ? given : pred);
    n_items++;
    if (rq.req == REQ_TICK) n_ticks++;
    if (rq.req == REQ_TICK && (pred.mix == 32'sh7FFFFFFF || pred.mix == 32'sh80000000))
      n_clipped++;
    if (pred.status != ST_OK) n_refused++;
    if (rq.req == REQ_WRITE) begin
      n_writes++;
      filled[rq.wave][rq.addr] = 1'b1;
      while (wr_prefix[rq.wave] < WAVE_DEPTH && filled[rq.wave][wr_prefix[rq.wave]])
        wr_prefix[rq.wave]++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) out_ready_i <= no_gaps || ($urandom_range(99) >= 21);

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    mix_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d mix %0d", $time, status_o,
                 mix_sample_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("slot_out", 64'(want.slot), 64'(slot_out_o));
        check_field("mix_sample", 64'($signed(want.mix)), 64'(mix_sample_o));
        check_field("active_voices", 64'(want.active), 64'(active_voices_o));
      end
    end
  end

  // Hang detector: counts cycles in which neither channel moves an item.
  always @(posedge clk_i) begin : hang_watch
    int quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               quiet, pending_results.size());
      $display("sample_voice_mixer_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed=1 carry a result that follows directly
  // from the rules: empty waves, idle slots, full voice pools, clipped mixes.
  // Quarter-scale extremes: 0x7FFFFFFF/4 = 536870911, eight of them clip high;
  // 0x80000000/4 = -536870912, eight of them clip low.
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_ITEMS] = '{
    // nothing playing: silent tick
    '{'{REQ_TICK, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    // empty waves refuse play and loop
    '{'{REQ_PLAY, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_EMPTY, 2'd0, 32'sd0, 4'd0}},
    '{'{REQ_LOOP, 2'd3, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_EMPTY, 2'd0, 32'sd0, 4'd0}},
    // unknown request with every other field at all ones
    '{'{REQ_UNUSED_A, 2'd3, 12'hFFF, 32'shFFFFFFFF, 13'h1FFF, 2'd3}, 1'b1,
      '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    // wave 0: max, min, and an odd negative that shows truncation toward zero
    '{'{REQ_WRITE, 2'd0, 12'd0, 32'sh7FFFFFFF, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    '{'{REQ_WRITE, 2'd0, 12'd1, 32'sh80000000, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    '{'{REQ_WRITE, 2'd0, 12'd2, -32'sd7, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    // last address of the last wave
    '{'{REQ_WRITE, 2'd3, 12'hFFF, -32'sd1, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    // oversize length clips to the wave depth, then a playable length
    '{'{REQ_SET_LEN, 2'd0, 12'd0, 32'sd0, 13'h1FFF, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    '{'{REQ_SET_LEN, 2'd0, 12'd0, 32'sd0, 13'd3, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    // fill every one-shot slot, then every loop slot, lowest first
    '{'{REQ_PLAY, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd1}},
    '{'{REQ_PLAY, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd1, 32'sd0, 4'd2}},
    '{'{REQ_PLAY, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd2, 32'sd0, 4'd3}},
    '{'{REQ_PLAY, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd3, 32'sd0, 4'd4}},
    '{'{REQ_LOOP, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd5}},
    '{'{REQ_LOOP, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd1, 32'sd0, 4'd6}},
    '{'{REQ_LOOP, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd2, 32'sd0, 4'd7}},
    '{'{REQ_LOOP, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_OK, 2'd3, 32'sd0, 4'd8}},
    // pools are full
    '{'{REQ_PLAY, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_NO_SLOT, 2'd0, 32'sd0, 4'd8}},
    '{'{REQ_LOOP, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1, '{ST_NO_SLOT, 2'd0, 32'sd0, 4'd8}},
    // eight voices on the extremes clip both ways
    '{'{REQ_TICK, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1,
      '{ST_OK, 2'd0, 32'sh7FFFFFFF, 4'd8}},
    '{'{REQ_TICK, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b1,
      '{ST_OK, 2'd0, 32'sh80000000, 4'd8}},
    // end of wave: one-shots free, loops wrap
    '{'{REQ_TICK, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd0}, 1'b0, '{ST_OK, 2'd0, 32'sd0, 4'd0}},
    // stop a running loop, then the same slot again while idle
    '{'{REQ_STOP, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd2}, 1'b1, '{ST_OK, 2'd0, 32'sd0, 4'd3}},
    '{'{REQ_STOP, 2'd0, 12'd0, 32'sd0, 13'd0, 2'd2}, 1'b1, '{ST_IDLE, 2'd0, 32'sd0, 4'd3}}
  };

  initial begin : stimulus
    mix_req_t rq;
    mix_rsp_t none;
    int       w;
    int       pick;
    bit       restore_due;
    int       restore_w;
    none        = '{ST_OK, 2'd0, 32'sd0, 4'd0};
    restore_due = 1'b0;
    restore_w   = 0;
    errors      = 0;
    no_gaps     = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[k]) issue_item(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].rsp);

    // Random part: mostly well-formed traffic. Writes grow each wave's written
    // run so lengths can grow, plays and loops fill the pools, ticks drain
    // them, and lengths change underneath running voices.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == 300) begin
        // hold off until the block has delivered everything
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      no_gaps = (k >= 500 && k < 700);

      // fields a request does not use carry random junk
      rq.req   = REQ_TICK;
      rq.wave  = 2'($urandom_range(3));
      rq.addr  = 12'($urandom_range(WAVE_DEPTH - 1));
      rq.value = $urandom;
      rq.len   = 13'($urandom_range(13'h1FFF));
      rq.slot  = 2'($urandom_range(3));
      w        = int'(rq.wave);
      pick     = $urandom_range(99);

      if (restore_due) begin
        // back to a safe length before any tick can read past the written run
        rq.req      = REQ_SET_LEN;
        rq.wave     = 2'(restore_w);
        rq.len      = safe_len(restore_w);
        restore_due = 1'b0;
      end else if (pick < 30) begin
        rq.req = REQ_WRITE;
        if (wr_prefix[w] < WAVE_DEPTH && $urandom_range(99) < 70) rq.addr = 12'(wr_prefix[w]);
        case ($urandom_range(7))
          0:       rq.value = 32'sh7FFFFFFF;
          1:       rq.value = 32'sh80000000;
          2:       rq.value = $urandom_range(16) - 8;  // small, odd negatives truncate
          default: ;
        endcase
      end else if (pick < 40) begin
        rq.req = REQ_SET_LEN;
        if ($urandom_range(9) == 0) begin
          rq.len      = 13'($urandom_range(13'h1FFF, WAVE_DEPTH));  // clips to depth
          restore_due = 1'b1;
          restore_w   = w;
        end else begin
          rq.len = safe_len(w);
        end
      end else if (pick < 55) begin
        rq.req = REQ_PLAY;
      end else if (pick < 67) begin
        rq.req = REQ_LOOP;
      end else if (pick < 77) begin
        rq.req = REQ_STOP;
      end else if (pick < 98) begin
        rq.req = REQ_TICK;
      end else begin
        rq.req = pick[0] ? REQ_UNUSED_A : REQ_UNUSED_B;
      end
      issue_item(rq, 1'b0, none);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests (%0d directed): %0d sample writes, %0d ticks, %0d clipped mixes",
             n_items, DIR_ITEMS, n_writes, n_ticks, n_clipped);
    $display("%0d requests refused; %0d mismatches", n_refused, errors);
    if (errors == 0) begin
      $display("sample_voice_mixer_core test passed");
    end else begin
      $display("sample_voice_mixer_core test failed");
    end
    $finish;
  end

endmodule
